// File: sv/hsv_pkg.sv
// Shared types, constants and helper function of the HSV to RGB converter.
`default_nettype none

package hsv_pkg;

  // Field widths of the color requests and results.
  localparam int unsigned HueW  = 13;
  localparam int unsigned ChanW = 8;
  localparam int unsigned FracW = 10;

  // One turn of the hue circle and the width of one sector, in 1/16 degree.
  localparam logic [HueW-1:0]  HueTurn   = 13'd5760;
  localparam logic [FracW-1:0] HueSector = 10'd960;

  // Full scale of a channel and of the product 255 * 960.
  localparam logic [ChanW-1:0] FracOne   = 8'd255;
  localparam logic [17:0]      ScaleFull = 18'd244800;

  // Reciprocal of 255: floor(2^16 / 255), leaves the quotient low by at most one.
  localparam logic [8:0]       RecipP     = 9'd257;
  localparam int unsigned      RecipPSh   = 16;
  // Reciprocal of 3825 (= 244800 / 64): floor(2^20 / 3825).
  localparam logic [8:0]       RecipQ     = 9'd274;
  localparam int unsigned      RecipQSh   = 20;
  localparam logic [11:0]      QDivisor   = 12'd3825;

  // Depth of the queue between the front and the back.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  // Sector of the hue circle, each 60 degrees wide.
  typedef enum logic [2:0] {
    SECT_0,
    SECT_1,
    SECT_2,
    SECT_3,
    SECT_4,
    SECT_5
  } sector_e;

  // One classified color request as it travels from the front to the back.
  typedef struct packed {
    sector_e            sector;
    logic [FracW-1:0]   frac;
    logic [ChanW-1:0]   sat;
    logic [ChanW-1:0]   val;
  } hsv_item_t;

  // One color result.
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // Start of a sector on the hue circle.
  function automatic logic [HueW-1:0] sector_base(sector_e sector);
    logic [HueW-1:0] base;
    unique case (sector)
      SECT_0:  base = 13'd0;
      SECT_1:  base = 13'd960;
      SECT_2:  base = 13'd1920;
      SECT_3:  base = 13'd2880;
      SECT_4:  base = 13'd3840;
      SECT_5:  base = 13'd4800;
      default: base = 13'd0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// File: sv/hsv_if.sv
// Valid/ready channel interfaces for color requests and color results.
`default_nettype none

interface hsv_in_if import hsv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] saturation;
  logic [ChanW-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv_out_if import hsv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// File: sv/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: front end, request queue and arithmetic back end.
//
// Usage:
// - hsv_i carries one color request per handshake: a 13-bit hue in 1/16 degree
//   (5760 and above counts as zero), and 8-bit saturation and brightness.
// - rgb_o returns one 8-bit red, green and blue result per request, in order.
// - Both channels use valid/ready; a request moves at a clock edge where both are high.
// - Throughput is one request per clock as long as the receiver takes results.
// - A request passes through the front register, the queue, and three arithmetic
//   stages ahead of the output register, which is the fourth; rgb_o.valid rises
//   once the result is in the output register.
// - When the receiver stalls, the back end holds its stages and the result waits in
//   the output register; the four-entry queue and the front register keep taking
//   requests, so up to nine requests can be in flight before hsv_i.ready falls.
// - Reset clears all valid flags and the queue; no result is pending after reset.
`default_nettype none

module hsv_to_rgb_converter import hsv_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hsv_in_if.sink     hsv_i,
  hsv_out_if.source  rgb_o
);

  hsv_item_t front_item;
  logic      front_valid;
  logic      fifo_full;
  hsv_item_t fifo_item;
  logic      fifo_empty;
  logic      back_ready;

  hsv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hsv_i        (hsv_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (!fifo_full)
  );

  hsv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (front_item),
    .push_i  (front_valid),
    .full_o  (fifo_full),
    .item_o  (fifo_item),
    .pop_i   (back_ready),
    .empty_o (fifo_empty)
  );

  hsv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (fifo_item),
    .item_valid_i (!fifo_empty),
    .item_ready_o (back_ready),
    .rgb_o        (rgb_o)
  );

endmodule

`default_nettype wire

// File: sv/hsv_front.sv
// Front end: takes color requests, zeroes a hue of one turn or more, splits it into sector and fraction.
`default_nettype none

module hsv_front import hsv_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hsv_in_if.sink     hsv_i,
  output hsv_item_t  item_o,
  output logic       item_valid_o,
  input  wire logic  item_ready_i
);

  logic            valid_q;
  hsv_item_t       item_q;
  hsv_item_t       item_d;
  sector_e         sector_d;
  logic [HueW-1:0] hue_wrap;
  logic [HueW-1:0] frac_full;
  logic            accept;

  // A hue of one turn or more counts as zero.
  assign hue_wrap = (hsv_i.hue >= HueTurn) ? '0 : hsv_i.hue;

  // Find the sector by comparing against the sector boundaries.
  always_comb begin
    priority if (hue_wrap >= 13'd4800) begin
      sector_d = SECT_5;
    end else if (hue_wrap >= 13'd3840) begin
      sector_d = SECT_4;
    end else if (hue_wrap >= 13'd2880) begin
      sector_d = SECT_3;
    end else if (hue_wrap >= 13'd1920) begin
      sector_d = SECT_2;
    end else if (hue_wrap >= 13'd960) begin
      sector_d = SECT_1;
    end else begin
      sector_d = SECT_0;
    end
  end

  assign frac_full = hue_wrap - sector_base(sector_d);

  // Pack the classified request.
  always_comb begin
    item_d        = '0;
    item_d.sector = sector_d;
    item_d.frac   = frac_full[FracW-1:0];
    item_d.sat    = hsv_i.saturation;
    item_d.val    = hsv_i.brightness;
  end

  // The output register takes a new request whenever it is empty or being drained.
  assign hsv_i.ready = !valid_q || item_ready_i;
  assign accept      = hsv_i.valid && hsv_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

`default_nettype wire

// File: sv/hsv_fifo.sv
// Short queue of classified requests between the front end and the arithmetic back end.
`default_nettype none

module hsv_fifo import hsv_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire hsv_item_t  item_i,
  input  wire logic       push_i,
  output logic            full_o,
  output hsv_item_t       item_o,
  input  wire logic       pop_i,
  output logic            empty_o
);

  hsv_item_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q;
  logic [FifoPtrW-1:0] rd_ptr_q;
  logic [FifoPtrW:0]   count_q;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == (FifoPtrW+1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: sv/hsv_back.sv
// Back end: four-stage pipeline that computes p, q and t and orders them per sector.
`default_nettype none

module hsv_back import hsv_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire hsv_item_t  item_i,
  input  wire logic       item_valid_i,
  output logic            item_ready_o,
  hsv_out_if.source       rgb_o
);

  logic adv;

  // Stage one: saturation times the fraction and its complement, value times 255 - sat.
  logic             v1_q;
  sector_e          sector1_q;
  logic [ChanW-1:0] val1_q;
  logic [17:0]      ks1_q;
  logic [17:0]      kt1_q;
  logic [15:0]      w1_q;
  logic [FracW-1:0] frac_cmp;

  // Stage two: value times the kept fraction, and the first estimate of p.
  logic             v2_q;
  sector_e          sector2_q;
  logic [ChanW-1:0] val2_q;
  logic [25:0]      xq2_q;
  logic [25:0]      xt2_q;
  logic [15:0]      w2_q;
  logic [ChanW-1:0] ep2_q;
  logic [17:0]      keep_q;
  logic [17:0]      keep_t;
  logic [23:0]      ep_prod;

  // Stage three: estimates of q and t, and the corrected p.
  logic             v3_q;
  sector_e          sector3_q;
  logic [ChanW-1:0] val3_q;
  logic [19:0]      yq3_q;
  logic [19:0]      yt3_q;
  logic [ChanW-1:0] eq3_q;
  logic [ChanW-1:0] et3_q;
  logic [ChanW-1:0] p3_q;
  logic [19:0]      yq;
  logic [19:0]      yt;
  logic [28:0]      eq_prod;
  logic [28:0]      et_prod;
  logic [15:0]      rp;

  // Stage four: corrected q and t, then the sector ordering into the output register.
  logic             out_valid_q;
  rgb_t             rgb_q;
  rgb_t             rgb_d;
  logic [19:0]      rq;
  logic [19:0]      rt;
  logic [ChanW-1:0] q4;
  logic [ChanW-1:0] t4;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv          = !out_valid_q || rgb_o.ready;
  assign item_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= item_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  assign frac_cmp = HueSector - item_i.frac;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sector1_q <= item_i.sector;
      val1_q    <= item_i.val;
      ks1_q     <= 18'(item_i.sat) * 18'(item_i.frac);
      kt1_q     <= 18'(item_i.sat) * 18'(frac_cmp);
      w1_q      <= 16'(item_i.val) * 16'(FracOne - item_i.sat);
    end
  end

  assign keep_q  = ScaleFull - ks1_q;
  assign keep_t  = ScaleFull - kt1_q;
  assign ep_prod = 24'(w1_q) * 24'(RecipP);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sector2_q <= sector1_q;
      val2_q    <= val1_q;
      xq2_q     <= 26'(val1_q) * 26'(keep_q);
      xt2_q     <= 26'(val1_q) * 26'(keep_t);
      w2_q      <= w1_q;
      ep2_q     <= ep_prod[RecipPSh +: ChanW];
    end
  end

  // Dividing by 244800 is a shift by six, then a divide by 3825.
  assign yq      = xq2_q[25:6];
  assign yt      = xt2_q[25:6];
  assign eq_prod = 29'(yq) * 29'(RecipQ);
  assign et_prod = 29'(yt) * 29'(RecipQ);
  assign rp      = w2_q - 16'(ep2_q) * 16'(FracOne);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sector3_q <= sector2_q;
      val3_q    <= val2_q;
      yq3_q     <= yq;
      yt3_q     <= yt;
      eq3_q     <= eq_prod[RecipQSh +: ChanW];
      et3_q     <= et_prod[RecipQSh +: ChanW];
      p3_q      <= ep2_q + ChanW'(rp >= 16'(FracOne));
    end
  end

  // The reciprocal estimates are at most one low; one compare fixes them.
  assign rq = yq3_q - 20'(eq3_q) * 20'(QDivisor);
  assign rt = yt3_q - 20'(et3_q) * 20'(QDivisor);
  assign q4 = eq3_q + ChanW'(rq >= 20'(QDivisor));
  assign t4 = et3_q + ChanW'(rt >= 20'(QDivisor));

  // Each sector has its own order of v, p, q and t. Zero saturation makes all four equal v.
  always_comb begin
    unique case (sector3_q)
      SECT_0:  rgb_d = '{red: val3_q, green: t4,     blue: p3_q};
      SECT_1:  rgb_d = '{red: q4,     green: val3_q, blue: p3_q};
      SECT_2:  rgb_d = '{red: p3_q,   green: val3_q, blue: t4};
      SECT_3:  rgb_d = '{red: p3_q,   green: q4,     blue: val3_q};
      SECT_4:  rgb_d = '{red: t4,     green: p3_q,   blue: val3_q};
      default: rgb_d = '{red: val3_q, green: p3_q,   blue: q4};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o.valid = out_valid_q;
  assign rgb_o.red   = rgb_q.red;
  assign rgb_o.green = rgb_q.green;
  assign rgb_o.blue  = rgb_q.blue;

endmodule

`default_nettype wire

// File: sv/hsv_checker.sv
// Port-level checks of the HSV to RGB converter and their binding to the top level.
`default_nettype none

module hsv_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [23:0] out_rgb_i
);

  localparam logic [3:0] MaxInFlight = 4'd9;

  logic [3:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Requests taken but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // A result that is not taken stays offered.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its color.
  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_rgb_i))
    else $error("result changed while stalled");

  // No result is offered without a request behind it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 4'd0)
    else $error("result without a pending request");

  // The front register, queue and pipeline bound the requests in flight.
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= MaxInFlight)
    else $error("more requests in flight than the block can hold");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (hsv_i.valid),
  .in_ready_i  (hsv_i.ready),
  .out_valid_i (rgb_o.valid),
  .out_ready_i (rgb_o.ready),
  .out_rgb_i   ({rgb_o.red, rgb_o.green, rgb_o.blue})
);

`default_nettype wire

// File: sim/hsv_to_rgb_converter_tb.sv
// Self-checking testbench for the HSV to RGB converter, with randomized stalls on both channels.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
  import hsv_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned StallLimit = 2000;
  // Cycles to wait after the last result.
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandomColors = 1250;
  localparam int unsigned MaxWait = 17;
  localparam int unsigned HueMax = (1 << HueW) - 1;

  // Index of each channel side in the idle phase bookkeeping.
  localparam int SideSend = 0;
  localparam int SideTake = 1;

  // Keeps the expected colors in request order and checks each result against the oldest.
  class rgb_scoreboard;
    rgb_t        expected_q[$];
    int unsigned error_count;

    function new();
      error_count = 0;
    endfunction

    // Exact integer form of the HSV to RGB conversion.
    function rgb_t convert_color(logic [HueW-1:0] hue, logic [ChanW-1:0] sat,
                                 logic [ChanW-1:0] val);
      rgb_t        color;
      sector_e     sector;
      int unsigned h, frac, s, v, full, span, p, q, t;
      s = sat;
      v = val;
      // Zero saturation is gray at the brightness, whatever the hue.
      if (s == 0) begin
        color.red   = val;
        color.green = val;
        color.blue  = val;
        return color;
      end
      // A hue of one full turn or more wraps to zero.
      h = (hue >= HueTurn) ? 0 : hue;
      span = HueSector;
      full = ScaleFull;
      sector = sector_e'(h / span);
      frac = h % span;
      p = (v * (int'(FracOne) - s)) / int'(FracOne);
      q = (v * (full - s * frac)) / full;
      t = (v * (full - s * (span - frac))) / full;
      case (sector)
        SECT_0: begin
          color = '{red: ChanW'(v), green: ChanW'(t), blue: ChanW'(p)};
        end
        SECT_1: begin
          color = '{red: ChanW'(q), green: ChanW'(v), blue: ChanW'(p)};
        end
        SECT_2: begin
          color = '{red: ChanW'(p), green: ChanW'(v), blue: ChanW'(t)};
        end
        SECT_3: begin
          color = '{red: ChanW'(p), green: ChanW'(q), blue: ChanW'(v)};
        end
        SECT_4: begin
          color = '{red: ChanW'(t), green: ChanW'(p), blue: ChanW'(v)};
        end
        default: begin
          color = '{red: ChanW'(v), green: ChanW'(p), blue: ChanW'(q)};
        end
      endcase
      return color;
    endfunction

    function void note_color(logic [HueW-1:0] hue, logic [ChanW-1:0] sat,
                             logic [ChanW-1:0] val);
      expected_q.push_back(convert_color(hue, sat, val));
    endfunction

    function void check_color(rgb_t got);
      rgb_t want;
      if (expected_q.size() == 0) begin
        $error("rgb result %0d/%0d/%0d arrived with no request pending",
               got.red, got.green, got.blue);
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        error_count++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        error_count++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        error_count++;
      end
    endfunction

    function int unsigned pending_count();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hsv_in_if  hsv_bus ();
  hsv_out_if rgb_bus ();

  rgb_scoreboard sb;
  int unsigned   idle_cycles;

  // Per-side idle phases: calm phases never wait, busy phases draw a wait per transfer.
  int unsigned phase_left [2];
  bit          phase_calm [2];

  hsv_to_rgb_converter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsv_i  (hsv_bus),
    .rgb_o  (rgb_bus)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic int unsigned draw_wait(int side);
    if (phase_left[side] == 0) begin
      phase_left[side] = $urandom_range(20, 90);
      phase_calm[side] = ($urandom_range(0, 2) == 0);
    end
    phase_left[side]--;
    return phase_calm[side] ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // Presents one color request and returns at the edge that accepts it.
  task automatic send_color(logic [HueW-1:0] hue, logic [ChanW-1:0] sat,
                            logic [ChanW-1:0] val);
    int unsigned gap;
    gap = draw_wait(SideSend);
    if (gap != 0) begin
      hsv_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    hsv_bus.valid      <= 1'b1;
    hsv_bus.hue        <= hue;
    hsv_bus.saturation <= sat;
    hsv_bus.brightness <= val;
    do @(posedge clk_i); while (!hsv_bus.ready);
  endtask

  function automatic logic [ChanW-1:0] draw_channel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return ChanW'($urandom);
    endcase
  endfunction

  // Mostly in-range hues, some on sector edges, some past a full turn.
  task automatic send_random_color();
    logic [HueW-1:0] hue;
    case ($urandom_range(0, 7))
      0: hue = HueW'($urandom_range(HueTurn, HueMax));
      1: hue = HueW'($urandom_range(0, 5) * HueSector + ($urandom_range(0, 1) ? HueSector - 1 : 0));
      default: hue = HueW'($urandom_range(0, HueTurn - 1));
    endcase
    send_color(hue, draw_channel(), draw_channel());
  endtask

  // Result side: takes one result per ready window, stalling at random in between.
  initial begin
    int unsigned stall;
    rgb_bus.ready = 1'b0;
    @(posedge clk_i);
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(SideTake);
      if (stall != 0) begin
        rgb_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rgb_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!rgb_bus.valid);
    end
  end

  // Handshake monitor and hang detection.
  always @(posedge clk_i) begin
    rgb_t got;
    if (rst_ni) begin
      if (hsv_bus.valid && hsv_bus.ready) begin
        sb.note_color(hsv_bus.hue, hsv_bus.saturation, hsv_bus.brightness);
      end
      if (rgb_bus.valid && rgb_bus.ready) begin
        got.red   = rgb_bus.red;
        got.green = rgb_bus.green;
        got.blue  = rgb_bus.blue;
        sb.check_color(got);
      end
      if ((hsv_bus.valid && hsv_bus.ready) || (rgb_bus.valid && rgb_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
          $display("hsv_to_rgb_converter_tb: errors");
          $finish;
        end
      end
    end
  end

  // Main sequence: reset, directed corners, random stream, drain and verdict.
  initial begin
    sb = new();
    idle_cycles = 0;
    phase_left = '{0, 0};
    phase_calm = '{1'b0, 1'b0};
    hsv_bus.valid      = 1'b0;
    hsv_bus.hue        = '0;
    hsv_bus.saturation = '0;
    hsv_bus.brightness = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both edges of every sector at full saturation and brightness.
    for (int sec = 0; sec < 6; sec++) begin
      send_color(HueW'(sec * HueSector), '1, '1);
      send_color(HueW'(sec * HueSector + HueSector - 1), '1, '1);
    end
    // Hue wrap: all-ones hue and a hue of exactly one full turn, then an in-range hue.
    send_color(HueW'(HueMax), '1, '1);
    send_color(HueTurn, 8'd200, 8'd200);
    send_color(HueW'(4096), 8'd180, 8'd90);
    // Gray cases, including one with an out-of-range hue.
    send_color(HueW'(3000), '0, 8'd123);
    send_color(HueW'(HueMax), '0, '1);
    send_color('0, '0, '0);
    // Brightness and saturation extremes.
    send_color(HueW'(1000), '1, '0);
    send_color(HueW'(2500), 8'd1, '1);
    send_color(HueW'(4000), '1, 8'd1);
    send_color(HueW'(5000), 8'd128, 8'd127);

    repeat (RandomColors) send_random_color();
    hsv_bus.valid <= 1'b0;

    // Drain: the watchdog ends the run if results stop arriving.
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.error_count == 0) begin
      $display("hsv_to_rgb_converter_tb: clean");
    end else begin
      $display("hsv_to_rgb_converter_tb: errors");
    end
    $finish;
  end

endmodule
